### hdl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared constants for the request striper: opcode codes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

  // Slot opcodes
  localparam logic [1:0] OP_READ      = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_WRITE_IMM = 2'd2;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int OFS_W   = 48;
  localparam int LEN_W   = 32;
  localparam int IMM_W   = 32;
  localparam int SLOT_W  = 8;
  localparam int QIDX_W  = 2;
  localparam int PIECE_W = 21;
  localparam int QCNT_W  = 3;
  localparam int CIS_W   = 7;
  localparam int SEQ_W   = 4;

endpackage

`default_nettype wire

### hdl/dma_request_striper.sv
// ----------------------------------------------------------------------------
// dma_request_striper
// Cuts transfer requests into chunks, stripes each chunk over the queue pairs
// and groups chunks into context slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request. Output channel
//   (out_valid/out_ready) returns queue_count elements per chunk, chunk by
//   chunk; last marks the final element of a request. A request of more than
//   MAX_CHUNKS chunks returns one element with too_long set and changes no
//   slot state.
//   cfg_write/cfg_data set queue_count; write it only while the block idles.
//   Sequence: in_ready is high only in the idle state. A request is planned
//   at one chunk of slot bookkeeping per cycle; then each chunk passes through
//   a setup state, the divider over a dividend of DW = clog2(MAX_CHUNK_LEN+1)+1
//   bits (22 at the default) and queue_count emitted elements. The per-queue
//   share comes from a one-bit-per-cycle restoring divider shared by all
//   chunks. A dropped request goes from idle to the drop state and back.
//   The output register holds a transfer while out_ready is low; emission
//   stalls with it and resumes one element per cycle.
//   Reset: synchronous, clears the slot counters, closes any open slot and
//   sets queue_count to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_request_striper
  import drs_pkg::*;
#(
  parameter int MAX_CHUNK_LEN = 1048576,
  parameter int MAX_BATCH     = 64,
  parameter int SLOT_RING     = 256,
  parameter int QUEUE_MAX     = 4,
  parameter int MAX_CHUNKS    = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  // configuration
  input  wire                      cfg_write,
  input  wire [QCNT_W-1:0]         cfg_data,
  // request channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [1:0]                cmd,
  input  wire [KEY_W-1:0]          local_key,
  input  wire [KEY_W-1:0]          remote_key,
  input  wire [OFS_W-1:0]          target_base,
  input  wire [OFS_W-1:0]          source_base,
  input  wire [LEN_W-1:0]          byte_count,
  input  wire signed [IMM_W-1:0]   immediate_value,
  input  wire                      final_request,
  // element channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [SLOT_W-1:0]        slot_index,
  output logic [QIDX_W-1:0]        queue_index,
  output logic [PIECE_W-1:0]       piece_length,
  output logic [KEY_W-1:0]         local_key_out,
  output logic [KEY_W-1:0]         remote_key_out,
  output logic [OFS_W-1:0]         target_ofs,
  output logic [OFS_W-1:0]         source_ofs,
  output logic [1:0]               slot_opcode,
  output logic signed [IMM_W-1:0]  immediate_out,
  output logic                     slot_closes,
  output logic                     last,
  output logic                     too_long
);

  // Derived sizes
  localparam int CLW = $clog2(MAX_CHUNK_LEN + 1);     // chunk length bits
  localparam int DW  = CLW + 1;                       // dividend bits
  localparam int DCW = $clog2(DW + 1);                // divider step count bits
  localparam int RW  = CLW + 3;                       // queue start bits
  localparam int CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam longint LIMIT = longint'(MAX_CHUNKS) * longint'(MAX_CHUNK_LEN);

  // State codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLAN  = 3'd1;
  localparam logic [2:0] S_CHUNK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_DROP  = 3'd5;

  logic [2:0]          state;

  // Configuration and slot state
  logic [QCNT_W-1:0]   nq;
  logic [SLOT_W-1:0]   next_slot;
  logic [CIS_W-1:0]    chunks_in_slot;
  logic                slot_open;
  logic [SLOT_W-1:0]   current_slot;

  // Request context
  logic [1:0]          req_cmd;
  logic [KEY_W-1:0]    req_lkey;
  logic [KEY_W-1:0]    req_rkey;
  logic [IMM_W-1:0]    req_imm;
  logic                req_fin;
  logic [OFS_W-1:0]    tchunk;
  logic [OFS_W-1:0]    schunk;
  logic [LEN_W-1:0]    plan_remain;
  logic [LEN_W-1:0]    emit_remain;

  // Per-chunk plan
  logic [SLOT_W-1:0]   c_slot  [MAX_CHUNKS];
  logic                c_close [MAX_CHUNKS];
  logic [SEQ_W-1:0]    c_seq   [MAX_CHUNKS];
  logic [SEQ_W-1:0]    seq;
  logic [SEQ_W-1:0]    final_seq;
  logic [CIW-1:0]      pc;
  logic [CIW-1:0]      last_chunk;
  logic [CIW-1:0]      chunk;

  // Shared divider and emit counters
  logic [CLW-1:0]      clen;
  logic [DW-1:0]       dvd;
  logic [QCNT_W-1:0]   rem;
  logic [DCW-1:0]      div_cnt;
  logic [RW-1:0]       rel;
  logic [QCNT_W-1:0]   q;

  // Combinational helpers
  logic                over_limit;
  logic                plan_tail;
  logic                call_tail;
  logic                open_now;
  logic [SEQ_W-1:0]    seq_new;
  logic [CIS_W-1:0]    cis_inc;
  logic                close_now;
  logic [SLOT_W-1:0]   next_slot_wrap;
  logic [CLW-1:0]      clen_cur;
  logic [QCNT_W:0]     rem_sh;
  logic                div_ge;
  logic [CLW-1:0]      share;
  logic [RW-1:0]       diff;
  logic [CLW-1:0]      elem_len;
  logic [1:0]          chunk_op;
  logic                out_free;
  logic                emit_fire;
  logic                q_last;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign emit_fire = out_free && ((state == S_EMIT) || (state == S_DROP));

  // Size check against the chunk limit
  assign over_limit = {3'b000, byte_count} > 35'(LIMIT);

  // Slot bookkeeping for the chunk under planning
  assign plan_tail      = plan_remain <= LEN_W'(MAX_CHUNK_LEN);
  assign call_tail      = req_fin && plan_tail;
  assign open_now       = !slot_open;
  assign seq_new        = open_now ? seq + 1'b1 : seq;
  assign cis_inc        = (open_now ? '0 : chunks_in_slot) + 1'b1;
  assign close_now      = call_tail || (cis_inc >= CIS_W'(MAX_BATCH));
  assign next_slot_wrap = (next_slot == SLOT_W'(SLOT_RING - 1)) ? '0 : next_slot + 1'b1;

  // Chunk length from the bytes still to go
  assign clen_cur = (emit_remain < LEN_W'(MAX_CHUNK_LEN)) ? CLW'(emit_remain)
                                                          : CLW'(MAX_CHUNK_LEN);

  // Restoring divider step
  assign rem_sh = {rem, dvd[DW-1]};
  assign div_ge = rem_sh >= {1'b0, nq};

  // Element length for queue q
  assign share    = dvd[CLW-1:0];
  assign diff     = RW'(clen) - rel;
  assign elem_len = (rel >= RW'(clen))     ? '0 :
                    (diff < RW'(share))    ? CLW'(diff) : share;
  assign q_last   = (q == nq - 1'b1);

  // Opcode of the current chunk's slot
  always_comb begin
    unique case (req_cmd)
      OP_WRITE_IMM: chunk_op = (req_fin && c_seq[chunk] == final_seq && final_seq != '0)
                               ? OP_WRITE_IMM : OP_WRITE;
      OP_WRITE:     chunk_op = OP_WRITE;
      default:      chunk_op = OP_READ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      nq             <= QCNT_W'(1);
      next_slot      <= '0;
      chunks_in_slot <= '0;
      slot_open      <= 1'b0;
      current_slot   <= '0;
      out_valid      <= 1'b0;
    end else begin
      // configuration: clamp into 1..QUEUE_MAX
      if (cfg_write) begin
        if (cfg_data == '0) begin
          nq <= QCNT_W'(1);
        end else if (int'(cfg_data) > QUEUE_MAX) begin
          nq <= QCNT_W'(QUEUE_MAX);
        end else begin
          nq <= cfg_data;
        end
      end

      // load a new output transfer, or drop the old one once taken
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_cmd     <= cmd;
            req_lkey    <= local_key;
            req_rkey    <= remote_key;
            req_imm     <= immediate_value;
            req_fin     <= final_request;
            tchunk      <= target_base;
            schunk      <= source_base;
            plan_remain <= byte_count;
            emit_remain <= byte_count;
            seq         <= '0;
            final_seq   <= '0;
            pc          <= '0;
            chunk       <= '0;
            state       <= over_limit ? S_DROP : S_PLAN;
          end
        end

        S_PLAN: begin
          // one chunk of slot bookkeeping per cycle
          if (open_now) begin
            current_slot <= next_slot;
            next_slot    <= next_slot_wrap;
          end
          c_slot[pc]     <= open_now ? next_slot : current_slot;
          c_close[pc]    <= close_now;
          c_seq[pc]      <= seq_new;
          seq            <= seq_new;
          slot_open      <= !close_now;
          chunks_in_slot <= close_now ? '0 : cis_inc;
          if (call_tail) begin
            final_seq <= seq_new;
          end
          if (plan_tail) begin
            last_chunk <= pc;
            state      <= S_CHUNK;
          end else begin
            plan_remain <= plan_remain - LEN_W'(MAX_CHUNK_LEN);
            pc          <= pc + 1'b1;
          end
        end

        S_CHUNK: begin
          // load the divider with ceil(clen / nq) setup
          clen    <= clen_cur;
          dvd     <= DW'(clen_cur) + DW'(nq) - DW'(1);
          rem     <= '0;
          div_cnt <= DCW'(DW);
          state   <= S_DIV;
        end

        S_DIV: begin
          // one quotient bit per cycle
          rem     <= div_ge ? QCNT_W'(rem_sh - {1'b0, nq}) : rem_sh[QCNT_W-1:0];
          dvd     <= {dvd[DW-2:0], div_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCW'(1)) begin
            rel   <= '0;
            q     <= '0;
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            slot_index     <= c_slot[chunk];
            queue_index    <= q[QIDX_W-1:0];
            piece_length   <= PIECE_W'(elem_len);
            local_key_out  <= req_lkey;
            remote_key_out <= req_rkey;
            target_ofs     <= tchunk + OFS_W'(rel);
            source_ofs     <= schunk + OFS_W'(rel);
            slot_opcode    <= chunk_op;
            immediate_out  <= (chunk_op == OP_WRITE_IMM) ? req_imm : '0;
            slot_closes    <= c_close[chunk] && q_last;
            last           <= q_last && (chunk == last_chunk);
            too_long       <= 1'b0;
            rel            <= rel + RW'(share);
            q              <= q + 1'b1;
            if (q_last) begin
              if (chunk == last_chunk) begin
                state <= S_IDLE;
              end else begin
                chunk       <= chunk + 1'b1;
                tchunk      <= tchunk + OFS_W'(MAX_CHUNK_LEN);
                schunk      <= schunk + OFS_W'(MAX_CHUNK_LEN);
                emit_remain <= emit_remain - LEN_W'(MAX_CHUNK_LEN);
                state       <= S_CHUNK;
              end
            end
          end
        end

        S_DROP: begin
          // single flagged transfer, slot state untouched
          if (out_free) begin
            slot_index     <= '0;
            queue_index    <= '0;
            piece_length   <= '0;
            local_key_out  <= '0;
            remote_key_out <= '0;
            target_ofs     <= '0;
            source_ofs     <= '0;
            slot_opcode    <= OP_READ;
            immediate_out  <= '0;
            slot_closes    <= 1'b0;
            last           <= 1'b1;
            too_long       <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_queue_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> q < nq && nq != '0)
    else $error("queue counter outside the configured count");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < nq)
    else $error("divider remainder not below the divisor");

  a_close_on_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_closes |-> queue_index == QIDX_W'(nq - 1'b1))
    else $error("slot closes on an element other than the last queue");

endmodule

`default_nettype wire
